// ----- hdl/concatenated_volume_extent_splitter_assert.svh -----
// Assertion macros used by the RTL of the extent splitter.
`ifndef CONCATENATED_VOLUME_EXTENT_SPLITTER_ASSERT_SVH
`define CONCATENATED_VOLUME_EXTENT_SPLITTER_ASSERT_SVH
`ifndef SYNTHESIS
// a must imply b in the same cycle
`define CVES_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("cves assertion failed");
// a must imply b in the next cycle
`define CVES_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("cves assertion failed");
// expression must hold in every cycle
`define CVES_ASSERT_ALWAYS(label, clk, rst_n, e) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (e)) \
		else $error("cves assertion failed");
`else
`define CVES_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define CVES_ASSERT_NEXT(label, clk, rst_n, a, b)
`define CVES_ASSERT_ALWAYS(label, clk, rst_n, e)
`endif
`endif

// ----- hdl/cves_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package cves_pkg;
	localparam int NUM_REGS       = 8;
	localparam int REG_IDX_W      = 3;
	localparam int DATA_W         = 32;
	localparam int IDX_W          = 3;
	localparam int TOTAL_W        = DATA_W + 3;
	localparam int MAX_PIECES_DEF = 8;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_END = 1'b1;

	// request token walking down the cell chain
	typedef struct packed {
		logic              valid;
		logic              fail;   // request runs past the volume end
		logic              zlen;   // zero-length request
		logic [DATA_W-1:0] skip;   // bytes still to skip before the request starts
		logic [DATA_W-1:0] rem;    // bytes still to place
	} tok_t;

	// segment offered by one cell
	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] offset;
		logic [DATA_W-1:0] length;
		logic              status;
		logic              last;
	} seg_t;
endpackage
`default_nettype wire

// ----- hdl/cves_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cves_cell (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   advance,
	input  wire cves_pkg::tok_t         tok_in,
	input  wire logic [cves_pkg::DATA_W-1:0] size,
	output cves_pkg::tok_t              tok_nxt,
	output cves_pkg::seg_t              seg,
	output logic                        busy
);
	import cves_pkg::*;

	tok_t              tok_q;
	logic              hit;
	logic              done;
	logic [DATA_W-1:0] room;
	logic [DATA_W-1:0] take;
	logic [DATA_W-1:0] rem_n;

	// token register: hold while the output side stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (advance || !tok_q.valid) begin
			tok_q <= tok_in;
		end
	end

	// piece arithmetic: does the request start in or run through this piece
	always_comb begin
		hit   = tok_q.skip < size;
		room  = size - tok_q.skip;
		take  = (room < tok_q.rem) ? room : tok_q.rem;
		rem_n = tok_q.rem - take;
		done  = tok_q.fail || (hit && (tok_q.zlen || rem_n == '0));

		seg.valid  = tok_q.valid && advance && (tok_q.fail || hit);
		seg.offset = tok_q.fail ? '0 : tok_q.skip;
		seg.length = tok_q.fail ? '0 : take;
		seg.status = tok_q.fail ? STATUS_END : STATUS_OK;
		seg.last   = done;

		// a piece the request has not reached yet leaves the byte count alone
		tok_nxt.valid = tok_q.valid && advance && !done;
		tok_nxt.fail  = 1'b0;
		tok_nxt.zlen  = tok_q.zlen;
		tok_nxt.skip  = hit ? '0 : (tok_q.skip - size);
		tok_nxt.rem   = hit ? rem_n : tok_q.rem;
	end

	assign busy = tok_q.valid;
endmodule
`default_nettype wire

// ----- hdl/concatenated_volume_extent_splitter.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "concatenated_volume_extent_splitter_assert.svh"
// Splits a (location, request_length) request over up to MAX_PIECES pieces
// laid end to end, giving one segment per piece touched, or a single
// disk-end result when the request passes the volume total. Piece sizes are
// written through cfg_we/cfg_index/cfg_data; the user must write them only
// while idle, as the block itself does not enforce this. A request is taken
// into the first cell of a chain with one cell per piece and moves one cell
// per cycle while out_ready does not stall the output; each cell emits at
// most one segment, and a zero-length request at the volume end passes
// through every cell. A new request is taken once the previous token has
// left the chain.
module concatenated_volume_extent_splitter #(
	parameter int MAX_PIECES = cves_pkg::MAX_PIECES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [cves_pkg::REG_IDX_W-1:0]   cfg_index,
	input  wire logic [cves_pkg::DATA_W-1:0]      cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [cves_pkg::DATA_W-1:0]      location,
	input  wire logic [cves_pkg::DATA_W-1:0]      request_length,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [cves_pkg::IDX_W-1:0]            piece_index,
	output logic [cves_pkg::DATA_W-1:0]           piece_offset,
	output logic [cves_pkg::DATA_W-1:0]           segment_length,
	output logic                                  status,
	output logic                                  last_segment
);
	import cves_pkg::*;

	logic [DATA_W-1:0]  piece_size_q [NUM_REGS];
	logic [TOTAL_W-1:0] total_q;
	tok_t               tok_link [MAX_PIECES+1];
	seg_t               seg_vec  [MAX_PIECES];
	logic [MAX_PIECES-1:0] busy_vec;
	logic               advance;
	logic               accept;
	logic [TOTAL_W-1:0] req_end;
	logic               sel_valid;
	seg_t               sel_seg;
	logic [IDX_W-1:0]   sel_idx;
	logic               out_valid_q;
	seg_t               out_q;
	logic [IDX_W-1:0]   out_idx_q;

	// configuration registers and running volume total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				piece_size_q[i] <= '0;
			end
			total_q <= '0;
		end else if (cfg_we) begin
			piece_size_q[cfg_index] <= cfg_data;
			if (int'(cfg_index) < MAX_PIECES) begin
				total_q <= total_q + TOTAL_W'(cfg_data)
					- TOTAL_W'(piece_size_q[cfg_index]);
			end
		end
	end

	// request entry and total check
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = busy_vec == '0;
	assign accept   = in_valid && in_ready;

	always_comb begin
		req_end            = TOTAL_W'(location) + TOTAL_W'(request_length);
		tok_link[0].valid  = accept;
		tok_link[0].fail   = req_end > total_q;
		tok_link[0].zlen   = request_length == '0;
		tok_link[0].skip   = location;
		tok_link[0].rem    = request_length;
	end

	// one cell per piece
	for (genvar g = 0; g < MAX_PIECES; g++) begin : g_cell
		cves_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.tok_in  (tok_link[g]),
			.size    (piece_size_q[g]),
			.tok_nxt (tok_link[g+1]),
			.seg     (seg_vec[g]),
			.busy    (busy_vec[g])
		);
	end

	// pick the emitting cell; a zero-length token leaving the chain ends at index 0
	always_comb begin
		sel_valid = 1'b0;
		sel_seg   = '0;
		sel_idx   = '0;
		for (int i = 0; i < MAX_PIECES; i++) begin
			if (seg_vec[i].valid) begin
				sel_valid = 1'b1;
				sel_seg   = seg_vec[i];
				sel_idx   = IDX_W'(i);
			end
		end
		if (tok_link[MAX_PIECES].valid && tok_link[MAX_PIECES].zlen) begin
			sel_valid      = 1'b1;
			sel_seg.valid  = 1'b1;
			sel_seg.offset = '0;
			sel_seg.length = '0;
			sel_seg.status = STATUS_OK;
			sel_seg.last   = 1'b1;
			sel_idx        = '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= sel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && sel_valid) begin
			out_q     <= sel_seg;
			out_idx_q <= sel_idx;
		end
	end

	assign out_valid      = out_valid_q;
	assign piece_index    = out_idx_q;
	assign piece_offset   = out_q.offset;
	assign segment_length = out_q.length;
	assign status         = out_q.status;
	assign last_segment   = out_q.last;

	// checks
	`CVES_ASSERT_ALWAYS(a_one_token, clk, arst_n, $onehot0(busy_vec))
	`CVES_ASSERT_NEXT(a_accept_loads_cell0, clk, arst_n, accept, busy_vec[0])
	`CVES_ASSERT_IMPLY(a_end_is_final, clk, arst_n, out_valid_q && status == STATUS_END, last_segment && segment_length == '0)
	`CVES_ASSERT_IMPLY(a_no_empty_mid, clk, arst_n, out_valid_q && !last_segment, segment_length != '0)
endmodule
`default_nettype wire
